// File: rtl/afm_pkg.sv
// Shared constants, register codes and scale tables of the autorange frequency meter.
// Used by afm_if.sv, afm_div.sv and autorange_frequency_meter_core.sv.
`default_nettype none
package afm_pkg;

	localparam int unsigned FREQ_W  = 46;  // millihertz result width
	localparam int unsigned COUNT_W = 32;  // counter word width
	localparam int unsigned GATE_W  = 14;  // gate factor width (max 10000)
	localparam int unsigned CHK_W   = FREQ_W + 4;  // room for 11x a result
	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DATA_W  = 32;

	localparam logic [COUNT_W-1:0] SWITCH_LIMIT = 32'd1000;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_GATE   = 2'd1,
		REG_REF    = 2'd2,
		REG_PER    = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		GATE_100MS = 2'd0,
		GATE_1S    = 2'd1,
		GATE_10S   = 2'd2
	} gate_sel_t;

	// counts per gate to millihertz
	function automatic logic [GATE_W-1:0] gate_factor(input logic en, input logic [1:0] sel);
		logic [GATE_W-1:0] k;
		k = GATE_W'(10000);
		if (en) begin
			unique case (sel)
				GATE_100MS: k = GATE_W'(10000);
				GATE_1S:    k = GATE_W'(1000);
				default:    k = GATE_W'(100);
			endcase
		end
		return k;
	endfunction

	// reference clock (mHz) times periods averaged: a power of ten 1e8 .. 1e13
	function automatic logic [FREQ_W-1:0] period_num(input logic en, input logic [1:0] ref_sel,
			input logic [1:0] per_sel);
		logic [1:0] per;
		logic [2:0] e;
		logic [FREQ_W-1:0] num;
		per = (per_sel == 2'd3) ? 2'd2 : per_sel;
		e   = {1'b0, ref_sel} + {1'b0, per};
		unique case (e)
			3'd0:    num = 46'd100_000_000;
			3'd1:    num = 46'd1_000_000_000;
			3'd2:    num = 46'd10_000_000_000;
			3'd3:    num = 46'd100_000_000_000;
			3'd4:    num = 46'd1_000_000_000_000;
			3'd5:    num = 46'd10_000_000_000_000;
			default: num = 46'd100_000_000;
		endcase
		if (!en) begin
			num = 46'd1_000_000_000;
		end
		return num;
	endfunction

endpackage
`default_nettype wire

// File: rtl/afm_if.sv
// Stream channels of the autorange frequency meter: poll items in, measurements out.
// Widths from afm_pkg.
`default_nettype none
interface afm_poll_if;
	logic                        valid;
	logic                        ready;
	logic                        freq_done;
	logic                        period_done;
	logic                        freq_ovf;
	logic                        period_ovf;
	logic                        freq_busy;
	logic                        period_busy;
	logic [afm_pkg::COUNT_W-1:0] freq_count;
	logic [afm_pkg::COUNT_W-1:0] period_count;

	modport source (output valid, freq_done, period_done, freq_ovf, period_ovf,
		freq_busy, period_busy, freq_count, period_count, input ready);
	modport sink (input valid, freq_done, period_done, freq_ovf, period_ovf,
		freq_busy, period_busy, freq_count, period_count, output ready);
endinterface

interface afm_meas_if;
	logic                        valid;
	logic                        ready;
	logic [afm_pkg::FREQ_W-1:0]  frequency_mhz;
	logic                        frequency_valid;
	logic                        using_period;
	logic                        freq_lamp;
	logic                        period_lamp;
	logic [afm_pkg::COUNT_W-1:0] freq_shown;
	logic [afm_pkg::COUNT_W-1:0] period_shown;

	modport source (output valid, frequency_mhz, frequency_valid, using_period, freq_lamp,
		period_lamp, freq_shown, period_shown, input ready);
	modport sink (input valid, frequency_mhz, frequency_valid, using_period, freq_lamp,
		period_lamp, freq_shown, period_shown, output ready);
endinterface
`default_nettype wire

// File: rtl/afm_div.sv
// Restoring divider, one quotient bit per cycle: 46-bit dividend by 32-bit divisor.
// Widths from afm_pkg.
`default_nettype none
module afm_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [afm_pkg::FREQ_W-1:0]  dividend,
	input  wire logic [afm_pkg::COUNT_W-1:0] divisor,
	output logic                             done,
	output logic [afm_pkg::FREQ_W-1:0]       quotient
);
	localparam int unsigned QW = afm_pkg::FREQ_W;
	localparam int unsigned DW = afm_pkg::COUNT_W;
	localparam int unsigned CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dvs_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;  // dividend bits shift out, quotient bits shift in
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          qbit;

	assign rem_sh  = {rem_q, quo_q[QW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign qbit    = !rem_sub[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// File: rtl/autorange_frequency_meter_core.sv
// Autorange frequency meter: poll decode, gate/period autorange, result check.
// Depends on afm_pkg, afm_if.sv (afm_poll_if, afm_meas_if) and afm_div.
//
// Usage:
//  - poll (sink): one transaction per poll of the counters (flags and both
//    count words). meas (source): exactly one transaction per poll with the
//    last frequency in mHz, its +-10% check, the mode, lamps and shown counts.
//  - APB port: four registers at byte addresses 0, 4, 8, 12 (enable, gate
//    select, reference clock select, periods select). Write only while idle.
//  - Path from accept to meas.valid: straight to the output state when the
//    poll gives no new result; a zero period count goes through x10 and two
//    bound compares, a gated result adds a multiply before them and a period
//    result the 46-step shift-subtract divider.
//  - poll.ready is high only in the idle state and returns with meas.valid.
//    The result goes to an output register, so the next poll is taken while
//    meas waits; a stalled meas holds a finished poll in its last state.
//  - Reset: no result yet (0 mHz, invalid), gate mode, lamps off, shown
//    counts 0, enable = 1, all selects 0.
`default_nettype none
module autorange_frequency_meter_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	afm_poll_if.sink                          poll,
	afm_meas_if.source                        meas,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [afm_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [afm_pkg::DATA_W-1:0]   pwdata,
	output logic      [afm_pkg::DATA_W-1:0]   prdata,
	output logic                              pready
);
	localparam int unsigned FW = afm_pkg::FREQ_W;
	localparam int unsigned CW = afm_pkg::COUNT_W;
	localparam int unsigned TW = afm_pkg::CHK_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_T10,
		ST_CHK_LO,
		ST_CHK_HI,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic       en_q;
	logic [1:0] gate_sel_q;
	logic [1:0] ref_sel_q;
	logic [1:0] per_sel_q;

	// meter state
	logic          pmode_q;
	logic [FW-1:0] prev_q;
	logic          ok_q;
	logic          flamp_q;
	logic          plamp_q;
	logic [CW-1:0] fhold_q;
	logic [CW-1:0] phold_q;
	logic          lo_ok_q;

	// datapath
	logic [CW-1:0] fc_q;
	logic [FW-1:0] f_q;
	logic [TW-1:0] t10_q;

	logic          meas_valid_q;
	logic [FW-1:0] meas_f_q;
	logic          meas_ok_q;
	logic          meas_pmode_q;
	logic          meas_flamp_q;
	logic          meas_plamp_q;
	logic [CW-1:0] meas_fhold_q;
	logic [CW-1:0] meas_phold_q;

	logic cfg_wr;
	logic poll_acc;
	logic do_gate;
	logic mode_sw;
	logic do_period;
	logic pc_zero;
	logic div_start;
	logic div_done;
	logic out_free;
	logic [FW-1:0] div_quo;
	logic [FW-1:0] prod;
	logic [TW-1:0] f_w;
	logic [TW-1:0] prev_w;
	logic [TW-1:0] t10;
	logic [TW-1:0] prev9;
	logic [TW-1:0] prev11;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (afm_pkg::reg_idx_t'(paddr[3:2]))
			afm_pkg::REG_ENABLE: prdata = {31'd0, en_q};
			afm_pkg::REG_GATE:   prdata = {30'd0, gate_sel_q};
			afm_pkg::REG_REF:    prdata = {30'd0, ref_sel_q};
			afm_pkg::REG_PER:    prdata = {30'd0, per_sel_q};
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q       <= 1'b1;
			gate_sel_q <= 2'd0;
			ref_sel_q  <= 2'd0;
			per_sel_q  <= 2'd0;
		end else if (cfg_wr) begin
			unique case (afm_pkg::reg_idx_t'(paddr[3:2]))
				afm_pkg::REG_ENABLE: en_q       <= pwdata[0];
				afm_pkg::REG_GATE:   gate_sel_q <= pwdata[1:0];
				afm_pkg::REG_REF:    ref_sel_q  <= pwdata[1:0];
				afm_pkg::REG_PER:    per_sel_q  <= pwdata[1:0];
				default:             ;
			endcase
		end
	end

	// poll decode: a low gated count switches to period mode, and a period
	// count ready in that same poll is used at once
	assign poll.ready = (state_q == ST_IDLE);
	assign poll_acc   = poll.valid && poll.ready;
	assign do_gate    = poll.freq_done && !pmode_q && (poll.freq_count >= afm_pkg::SWITCH_LIMIT);
	assign mode_sw    = pmode_q
		|| (poll.freq_done && (poll.freq_count < afm_pkg::SWITCH_LIMIT));
	assign do_period  = poll.period_done && mode_sw;
	assign pc_zero    = (poll.period_count == '0);
	assign div_start  = poll_acc && do_period && !pc_zero;

	afm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (afm_pkg::period_num(en_q, ref_sel_q, per_sel_q)),
		.divisor  (poll.period_count),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign prod   = fc_q * afm_pkg::gate_factor(en_q, gate_sel_q);
	assign f_w    = {4'd0, f_q};
	assign prev_w = {4'd0, prev_q};
	assign t10    = (f_w << 3) + (f_w << 1);
	assign prev9  = (prev_w << 3) + prev_w;
	assign prev11 = prev9 + (prev_w << 1);

	assign out_free = !meas_valid_q || meas.ready;

	always_ff @(posedge clk) begin
		if (poll_acc) begin
			fc_q <= poll.freq_count;
			f_q  <= '0;  // zero period count gives 0 mHz
		end
		if (state_q == ST_MUL) begin
			f_q <= prod;
		end
		if (div_done) begin
			f_q <= div_quo;
		end
		if (state_q == ST_T10) begin
			t10_q <= t10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pmode_q      <= 1'b0;
			prev_q       <= '0;
			ok_q         <= 1'b0;
			flamp_q      <= 1'b0;
			plamp_q      <= 1'b0;
			fhold_q      <= '0;
			phold_q      <= '0;
			lo_ok_q      <= 1'b0;
			meas_valid_q <= 1'b0;
			meas_f_q     <= '0;
			meas_ok_q    <= 1'b0;
			meas_pmode_q <= 1'b0;
			meas_flamp_q <= 1'b0;
			meas_plamp_q <= 1'b0;
			meas_fhold_q <= '0;
			meas_phold_q <= '0;
		end else begin
			// in ST_OUT the output register is reloaded instead
			if (meas_valid_q && meas.ready && (state_q != ST_OUT)) begin
				meas_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (poll_acc) begin
						flamp_q <= flamp_q ? !poll.freq_done : poll.freq_busy;
						plamp_q <= plamp_q ? !poll.period_done : poll.period_busy;
						if (poll.freq_ovf) begin
							fhold_q <= '1;
						end else if (poll.freq_done) begin
							fhold_q <= poll.freq_count;
						end
						if (poll.period_ovf) begin
							phold_q <= '1;
						end else if (poll.period_done) begin
							phold_q <= poll.period_count;
						end
						pmode_q <= mode_sw && !poll.period_done;
						if (do_gate) begin
							state_q <= ST_MUL;
						end else if (do_period) begin
							state_q <= pc_zero ? ST_T10 : ST_DIV;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MUL: state_q <= ST_T10;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_T10;
					end
				end
				ST_T10: state_q <= ST_CHK_LO;
				ST_CHK_LO: begin
					lo_ok_q <= (t10_q >= prev9);
					state_q <= ST_CHK_HI;
				end
				ST_CHK_HI: begin
					ok_q    <= lo_ok_q && (t10_q <= prev11);
					prev_q  <= f_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						meas_valid_q <= 1'b1;
						meas_f_q     <= prev_q;
						meas_ok_q    <= ok_q;
						meas_pmode_q <= pmode_q;
						meas_flamp_q <= flamp_q;
						meas_plamp_q <= plamp_q;
						meas_fhold_q <= fhold_q;
						meas_phold_q <= phold_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign meas.valid           = meas_valid_q;
	assign meas.frequency_mhz   = meas_f_q;
	assign meas.frequency_valid = meas_ok_q;
	assign meas.using_period    = meas_pmode_q;
	assign meas.freq_lamp       = meas_flamp_q;
	assign meas.period_lamp     = meas_plamp_q;
	assign meas.freq_shown      = meas_fhold_q;
	assign meas.period_shown    = meas_phold_q;
endmodule
`default_nettype wire
